[sv/mfat_pkg.sv]
`timescale 1ns / 1ps

package mfat_pkg;

    // Slot layout: four group slots, then the single slot and the other motor.
    localparam int MOTOR_SLOTS = 6;
    localparam int SLOT_W      = 3;
    localparam logic [SLOT_W-1:0] SLOT_SINGLE = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_OTHER  = 3'd5;

    // Encoder constants: half a turn and the activity period of the group slots.
    localparam logic signed [16:0] HALF_TURN       = 17'sd4096;
    localparam logic [8:0]         ACTIVITY_PERIOD = 9'd500;
    localparam logic [15:0]        COUNT_MAX       = 16'hFFFF;

    // Register reset values.
    localparam logic [10:0] GROUP_BASE_RESET  = 11'd513;
    localparam logic [10:0] SINGLE_SLOT_RESET = 11'd517;
    localparam logic [10:0] OTHER_MOTOR_RESET = 11'd522;
    localparam logic [15:0] CAL_FRAMES_RESET  = 16'd50;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_GROUP_BASE  = 2'd0,
        REG_SINGLE_SLOT = 2'd1,
        REG_OTHER_MOTOR = 2'd2,
        REG_CAL_FRAMES  = 2'd3
    } mfat_reg_t;

    typedef struct packed {
        logic [10:0] group_base_id;
        logic [10:0] single_slot_id;
        logic [10:0] other_motor_id;
        logic [15:0] calibration_frames;
    } mfat_cfg_t;

    typedef struct packed {
        logic               from_second_bus;
        logic [10:0]        frame_id;
        logic [15:0]        angle_raw;
        logic signed [15:0] speed_raw;
        logic [15:0]        current_raw;
        logic [7:0]         hall_raw;
    } mfat_frame_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } mfat_match_t;

    typedef struct packed {
        logic               matched;
        logic [SLOT_W-1:0]  slot;
        logic               calibrating;
        logic [15:0]        angle_now;
        logic signed [15:0] speed_out;
        logic [18:0]        current_scaled;
        logic [7:0]         hall_value;
        logic signed [31:0] turn_count;
        logic signed [31:0] angle_total;
        logic               led_toggle;
    } mfat_result_t;

endpackage

[sv/mfat_slot_match.sv]
`timescale 1ns / 1ps

module mfat_slot_match (
    input  mfat_pkg::mfat_cfg_t   cfg,
    input  mfat_pkg::mfat_frame_t frame,
    output mfat_pkg::mfat_match_t match
);
    import mfat_pkg::*;

    logic [11:0] group_diff;
    logic        group_hit;

    // Offset from the group base; a borrow means the identifier lies below it.
    assign group_diff = {1'b0, frame.frame_id} - {1'b0, cfg.group_base_id};
    assign group_hit  = !group_diff[11] && (group_diff[10:2] == 9'd0);

    // The group wins over the single slot, and the single slot over the other motor.
    always_comb begin
        match.hit  = 1'b0;
        match.slot = '0;
        priority if (!frame.from_second_bus) begin
            match.hit = 1'b0;
        end else if (group_hit) begin
            match.hit  = 1'b1;
            match.slot = {1'b0, group_diff[1:0]};
        end else if (frame.frame_id == cfg.single_slot_id) begin
            match.hit  = 1'b1;
            match.slot = SLOT_SINGLE;
        end else if (frame.frame_id == cfg.other_motor_id) begin
            match.hit  = 1'b1;
            match.slot = SLOT_OTHER;
        end else begin
            match.hit = 1'b0;
        end
    end

endmodule

[sv/mfat_slot_track.sv]
`timescale 1ns / 1ps

module mfat_slot_track (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic [15:0]            calibration_frames,
    input  mfat_pkg::mfat_frame_t  frame,
    input  mfat_pkg::mfat_match_t  match,
    output mfat_pkg::mfat_result_t result
);
    import mfat_pkg::*;

    logic [15:0] count_reg  [MOTOR_SLOTS];
    logic [15:0] angle_reg  [MOTOR_SLOTS];
    logic [15:0] offset_reg [MOTOR_SLOTS];
    logic [31:0] turns_reg  [MOTOR_SLOTS];
    logic [8:0]  activity_reg;
    logic [8:0]  activity_next;

    logic [15:0]        cur_count;
    logic [15:0]        cur_angle;
    logic [15:0]        cur_offset;
    logic [31:0]        cur_turns;
    logic               calib;
    logic [15:0]        count_next;
    logic [15:0]        offset_next;
    logic [31:0]        turns_next;
    logic signed [16:0] angle_diff;
    logic [31:0]        total;
    logic               group_slot;
    logic [8:0]         activity_inc;
    logic               led;

    // Read the state of the addressed slot.
    assign cur_count  = count_reg[match.slot];
    assign cur_angle  = angle_reg[match.slot];
    assign cur_offset = offset_reg[match.slot];
    assign cur_turns  = turns_reg[match.slot];

    // Calibration decision and saturating frame count.
    assign calib      = cur_count <= calibration_frames;
    assign count_next = (cur_count == COUNT_MAX) ? cur_count : cur_count + 16'd1;

    // Unwrap: a jump of more than half a turn moves the turn counter.
    assign angle_diff = $signed({1'b0, frame.angle_raw}) - $signed({1'b0, cur_angle});

    always_comb begin
        turns_next = cur_turns;
        priority if (calib) begin
            turns_next = cur_turns;
        end else if (angle_diff > HALF_TURN) begin
            turns_next = cur_turns - 32'd1;
        end else if (angle_diff < -HALF_TURN) begin
            turns_next = cur_turns + 32'd1;
        end else begin
            turns_next = cur_turns;
        end
    end

    assign offset_next = calib ? frame.angle_raw : cur_offset;
    assign total = {turns_next[18:0], 13'd0} + {16'd0, frame.angle_raw}
                   - {16'd0, offset_next};

    // Activity counter for the group slots; it never passes the period.
    assign group_slot   = match.hit && !match.slot[2];
    assign activity_inc = activity_reg + 9'd1;
    assign led          = group_slot && (activity_inc == ACTIVITY_PERIOD);

    always_comb begin
        activity_next = activity_reg;
        if (group_slot) begin
            activity_next = led ? 9'd0 : activity_inc;
        end
    end

    // Result word; an unmatched frame gives all zeros.
    always_comb begin
        result = '0;
        if (match.hit) begin
            result.matched     = 1'b1;
            result.slot        = match.slot;
            result.calibrating = calib;
            result.angle_now   = frame.angle_raw;
            result.turn_count  = turns_next;
            result.angle_total = total;
            result.led_toggle  = led;
            if (!calib) begin
                result.speed_out      = frame.speed_raw;
                result.current_scaled = {1'b0, frame.current_raw, 2'b00}
                                        + {3'd0, frame.current_raw};
                result.hall_value     = frame.hall_raw;
            end
        end
    end

    // Slot state update when the frame moves on to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTOR_SLOTS; i++) begin
                count_reg[i]  <= '0;
                angle_reg[i]  <= '0;
                offset_reg[i] <= '0;
                turns_reg[i]  <= '0;
            end
            activity_reg <= '0;
        end else if (advance && match.hit) begin
            count_reg[match.slot]  <= count_next;
            angle_reg[match.slot]  <= frame.angle_raw;
            offset_reg[match.slot] <= offset_next;
            turns_reg[match.slot]  <= turns_next;
            activity_reg           <= activity_next;
        end
    end

endmodule

[sv/motor_feedback_angle_tracker.sv]
`timescale 1ns / 1ps

// Motor feedback angle tracker.
// The s_ channel takes one received feedback frame per word: tuser carries the
// bus flag, tdata the identifier and the decoded data bytes. The m_ channel
// gives exactly one result word for every frame taken, in order; frames that
// no slot takes give a result with every field zero.
// A frame is registered in the input register, where the slot state is read,
// updated and the result formed; it then waits in the output register. One
// word per cycle is sustained while the receiver takes results; the slot state
// is read, modified and written back while the frame is in the input register.
// If the receiver stalls, the result is held and the input register still
// takes one more frame; s_tready then drops until the result is taken.
// The APB port sets the identifiers and calibration length; the user writes
// it only while no frames are in flight (unenforced). pready is always high.
// A synchronous reset restores the register defaults, clears every slot's
// frame count, angle, offset and turn counter, the activity counter, and
// empties both registers; no clearing pass is needed.
module motor_feedback_angle_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    // Input frames.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: frame_id[10:0], angle_raw[26:11], speed_raw[42:27],
    //        current_raw[58:43], hall_raw[66:59], zero fill[71:67]
    input  logic [71:0]  s_tdata,
    // tuser: from_second_bus[0]
    input  logic [0:0]   s_tuser,
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: angle_now[15:0], speed_out[31:16], current_scaled[50:32],
    //        hall_value[58:51], turn_count[90:59], angle_total[122:91],
    //        led_toggle[123], zero fill[127:124]
    output logic [127:0] m_tdata,
    // tuser: matched[0], slot[3:1], calibrating[4]
    output logic [4:0]   m_tuser,
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mfat_pkg::*;

    mfat_cfg_t    cfg_reg;
    mfat_reg_t    reg_sel;
    logic         cfg_write;

    logic         in_valid_reg;
    mfat_frame_t  in_frame_reg;
    logic         out_valid_reg;
    mfat_result_t out_res_reg;
    logic         advance;

    mfat_match_t  match;
    mfat_result_t result;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_sel   = mfat_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.group_base_id      <= GROUP_BASE_RESET;
            cfg_reg.single_slot_id     <= SINGLE_SLOT_RESET;
            cfg_reg.other_motor_id     <= OTHER_MOTOR_RESET;
            cfg_reg.calibration_frames <= CAL_FRAMES_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_GROUP_BASE:  cfg_reg.group_base_id      <= pwdata[10:0];
                REG_SINGLE_SLOT: cfg_reg.single_slot_id     <= pwdata[10:0];
                REG_OTHER_MOTOR: cfg_reg.other_motor_id     <= pwdata[10:0];
                REG_CAL_FRAMES:  cfg_reg.calibration_frames <= pwdata[15:0];
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_GROUP_BASE:  prdata = {21'd0, cfg_reg.group_base_id};
            REG_SINGLE_SLOT: prdata = {21'd0, cfg_reg.single_slot_id};
            REG_OTHER_MOTOR: prdata = {21'd0, cfg_reg.other_motor_id};
            REG_CAL_FRAMES:  prdata = {16'd0, cfg_reg.calibration_frames};
        endcase
    end

    // Pipeline control: the input register moves on when the output is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_frame_reg.from_second_bus <= s_tuser[0];
            in_frame_reg.frame_id        <= s_tdata[10:0];
            in_frame_reg.angle_raw       <= s_tdata[26:11];
            in_frame_reg.speed_raw       <= s_tdata[42:27];
            in_frame_reg.current_raw     <= s_tdata[58:43];
            in_frame_reg.hall_raw        <= s_tdata[66:59];
        end
    end

    mfat_slot_match u_match (
        .cfg   (cfg_reg),
        .frame (in_frame_reg),
        .match (match)
    );

    mfat_slot_track u_track (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .advance            (advance),
        .calibration_frames (cfg_reg.calibration_frames),
        .frame              (in_frame_reg),
        .match              (match),
        .result             (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.calibrating, out_res_reg.slot, out_res_reg.matched};
    assign m_tdata  = {4'd0,
                       out_res_reg.led_toggle,
                       out_res_reg.angle_total,
                       out_res_reg.turn_count,
                       out_res_reg.hall_value,
                       out_res_reg.current_scaled,
                       out_res_reg.speed_out,
                       out_res_reg.angle_now};

`ifndef NO_ASSERTIONS
    // A toggle pulse comes only with a matched group slot frame.
    a_led_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.led_toggle) |->
            (out_res_reg.matched && !out_res_reg.slot[2]))
        else $error("led toggle without a group slot frame");

    // An unmatched frame gives an all-zero result.
    a_unmatched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_res_reg.matched) |-> (m_tdata == '0 && m_tuser == '0))
        else $error("unmatched result carries data");

    // A calibrating frame reports no measurement data.
    a_calib_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.calibrating) |->
            (out_res_reg.speed_out == '0 && out_res_reg.current_scaled == '0
             && out_res_reg.hall_value == '0))
        else $error("calibrating result carries measurement data");

    // The input side stalls only when both registers hold a word.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule
